>>> rtl/banded_symmetric_matvec_unit_assert.svh
// Assertion helpers for the banded symmetric matvec unit.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef BANDED_SYMMETRIC_MATVEC_UNIT_ASSERT_SVH
`define BANDED_SYMMETRIC_MATVEC_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BSMV_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BSMV_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/bsmv_pkg.sv
package bsmv_pkg;

  // Storage geometry
  localparam int MAX_ORDER     = 4096;
  localparam int NUM_DIAGONALS = 5;
  localparam int OFFSET_REGS   = 4;
  localparam int DIAG_LIMIT    = (NUM_DIAGONALS < OFFSET_REGS + 1) ?
                                 NUM_DIAGONALS : OFFSET_REGS + 1;
  localparam int ADDR_W        = $clog2(MAX_ORDER);
  localparam int ORD_W         = $clog2(MAX_ORDER + 1);
  localparam int BANK_W        = (NUM_DIAGONALS > 1) ? $clog2(NUM_DIAGONALS) : 1;

  // Query schedule: main term plus a lower and an upper term per off-diagonal,
  // then a drain of the read and multiply registers.
  localparam int TERMS     = 2 * DIAG_LIMIT - 1;
  localparam int LAST_STEP = TERMS + 1;
  localparam int STEP_W    = $clog2(LAST_STEP + 1);

  // Field widths
  localparam int ACT_W  = 2;
  localparam int ROW_W  = 12;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int DIM_W  = 13;
  localparam int DCNT_W = 3;
  localparam int OFF_W  = 12;
  localparam int CIDX_W = 3;
  localparam int CDAT_W = 13;

  // Arithmetic: Q24.40 products, exact sum of up to TERMS of them
  localparam int PROD_W = 2 * VAL_W;
  localparam int ACC_W  = PROD_W + $clog2(TERMS + 1);
  localparam int FRAC_W = 20;

  // Actions
  localparam logic [ACT_W-1:0] ACT_ENTRY  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_VECTOR = 2'd1;
  localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE  = 2'd1;
  localparam logic [STAT_W-1:0] ST_NODIAG = 2'd2;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_DIMENSION = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_DIAG_CNT  = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_OFFSET_1  = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_OFFSET_2  = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_OFFSET_3  = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_OFFSET_4  = 3'd5;

  // Control from the sequencer to the MAC unit
  typedef struct packed {
    logic clr;      // zero product and accumulator
    logic term_ok;  // read data in this cycle is a term in range
    logic acc_en;   // fold the product register into the accumulator
  } mac_ctl_t;

endpackage

>>> rtl/bsmv_ram.sv
module bsmv_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/bsmv_mac.sv
module bsmv_mac (
  input  logic                            clk,
  input  bsmv_pkg::mac_ctl_t              ctl,
  input  logic signed [bsmv_pkg::VAL_W-1:0] coef,
  input  logic signed [bsmv_pkg::VAL_W-1:0] vec,
  output logic signed [bsmv_pkg::VAL_W-1:0] result
);

  localparam int RND_W = bsmv_pkg::ACC_W - bsmv_pkg::FRAC_W;
  localparam logic signed [RND_W-1:0] SAT_HI = RND_W'((64'sd1 <<< (bsmv_pkg::VAL_W - 1)) - 1);
  localparam logic signed [RND_W-1:0] SAT_LO = RND_W'(-(64'sd1 <<< (bsmv_pkg::VAL_W - 1)));
  localparam logic signed [bsmv_pkg::ACC_W-1:0] HALF_LSB =
    bsmv_pkg::ACC_W'(64'sd1 <<< (bsmv_pkg::FRAC_W - 1));

  logic signed [bsmv_pkg::PROD_W-1:0] prod_r;
  logic signed [bsmv_pkg::ACC_W-1:0]  acc_r;
  logic signed [bsmv_pkg::ACC_W-1:0]  acc_rnd;
  logic signed [RND_W-1:0]            q_rnd;

  // multiply stage (signed 32x32 to 64), then exact accumulate
  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      prod_r <= '0;
      acc_r  <= '0;
    end else begin
      if (ctl.term_ok) begin
        prod_r <= coef * vec;
      end else begin
        prod_r <= '0;
      end
      if (ctl.acc_en) begin
        acc_r <= acc_r + bsmv_pkg::ACC_W'(prod_r);
      end
    end
  end

  // round half up to Q12.20, then saturate
  always_comb begin
    acc_rnd = acc_r + HALF_LSB;
    q_rnd   = acc_rnd[bsmv_pkg::ACC_W-1:bsmv_pkg::FRAC_W];
    if (q_rnd > SAT_HI) begin
      result = SAT_HI[bsmv_pkg::VAL_W-1:0];
    end else if (q_rnd < SAT_LO) begin
      result = SAT_LO[bsmv_pkg::VAL_W-1:0];
    end else begin
      result = q_rnd[bsmv_pkg::VAL_W-1:0];
    end
  end

endmodule

>>> rtl/banded_symmetric_matvec_unit.sv
// Banded symmetric matrix times vector, signed Q12.20.
// Input beat: start with in_action/in_row/in_column/in_value, taken at an edge
// where start is high and busy is low. Actions: entry write, vector write,
// product query; the fourth code is ignored and answers ok.
// Result beat: out_valid is high for one cycle with out_status/out_product;
// every input beat yields exactly one result beat and the receiver cannot stall.
// Config: cfg_we writes cfg_wdata to register cfg_index in the same edge;
// write only while no item is in flight.
// Timing: a write or ignored beat keeps busy high through S_EXEC only; its result
// is registered as S_EXEC ends. A query walks 2*5-1 = 9 terms through one shared
// 32x32 multiplier and accumulator, one term per cycle, plus read and multiply
// pipeline drain in S_MAC, then rounds in S_ROUND; busy stays high throughout, so
// a new beat is taken only after the query result has been registered.
// Reset: configuration and sequencer registers return to their defaults and both
// stores are swept to zero, one address per cycle across all banks at once: busy
// stays high after rst_n is released until the sweep reaches the last address.
`include "banded_symmetric_matvec_unit_assert.svh"

module banded_symmetric_matvec_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // command channel
  input  logic                                 start,
  output logic                                 busy,
  input  logic [bsmv_pkg::ACT_W-1:0]           in_action,
  input  logic [bsmv_pkg::ROW_W-1:0]           in_row,
  input  logic [bsmv_pkg::ROW_W-1:0]           in_column,
  input  logic signed [bsmv_pkg::VAL_W-1:0]    in_value,
  // result channel
  output logic                                 out_valid,
  output logic [bsmv_pkg::STAT_W-1:0]          out_status,
  output logic signed [bsmv_pkg::VAL_W-1:0]    out_product,
  // configuration
  input  logic                                 cfg_we,
  input  logic [bsmv_pkg::CIDX_W-1:0]          cfg_index,
  input  logic [bsmv_pkg::CDAT_W-1:0]          cfg_wdata
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_MAC,
    S_ROUND
  } state_t;

  localparam int ADDR_W = bsmv_pkg::ADDR_W;
  localparam logic [bsmv_pkg::ORD_W-1:0] ORD_MAX = bsmv_pkg::ORD_W'(bsmv_pkg::MAX_ORDER);
  localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(bsmv_pkg::MAX_ORDER - 1);
  localparam logic [bsmv_pkg::DCNT_W-1:0] DIAG_MAX = bsmv_pkg::DCNT_W'(bsmv_pkg::DIAG_LIMIT);
  localparam logic [bsmv_pkg::STEP_W-1:0] STEP_LAST = bsmv_pkg::STEP_W'(bsmv_pkg::LAST_STEP);
  localparam logic [bsmv_pkg::STEP_W-1:0] STEP_TERMS = bsmv_pkg::STEP_W'(bsmv_pkg::TERMS);

  state_t                               state_r;
  logic [ADDR_W-1:0]                    clr_addr_r;
  logic [bsmv_pkg::STEP_W-1:0]          step_r;
  logic                                 term_ok_d_r;
  logic [bsmv_pkg::BANK_W-1:0]          bank_d_r;

  // latched item
  logic [bsmv_pkg::ACT_W-1:0]           act_r;
  logic [bsmv_pkg::ROW_W-1:0]           row_r;
  logic [bsmv_pkg::ROW_W-1:0]           col_r;
  logic [bsmv_pkg::VAL_W-1:0]           val_r;

  // configuration
  logic [bsmv_pkg::DIM_W-1:0]           dim_r;
  logic [bsmv_pkg::DCNT_W-1:0]          dcnt_r;
  logic [bsmv_pkg::OFF_W-1:0]           off_r [bsmv_pkg::OFFSET_REGS];

  // result registers
  logic                                 out_valid_r;
  logic [bsmv_pkg::STAT_W-1:0]          out_status_r;
  logic [bsmv_pkg::VAL_W-1:0]           out_product_r;

  // decode
  logic [bsmv_pkg::ORD_W-1:0]           n_use;
  logic [bsmv_pkg::DCNT_W-1:0]          m_use;
  logic [bsmv_pkg::OFF_W-1:0]           offs [bsmv_pkg::DIAG_LIMIT];
  logic [bsmv_pkg::ROW_W-1:0]           hi_idx;
  logic [bsmv_pkg::ROW_W-1:0]           lo_idx;
  logic [bsmv_pkg::ROW_W-1:0]           diff;
  logic                                 hit;
  logic [bsmv_pkg::BANK_W-1:0]          hit_bank;
  logic                                 range_bad;
  logic                                 query_go;
  logic                                 entry_we;
  logic                                 vec_we_op;
  logic [bsmv_pkg::STAT_W-1:0]          exec_status;

  // query step decode
  logic [bsmv_pkg::STEP_W-1:0]          k_raw;
  logic                                 lower;
  logic [bsmv_pkg::OFF_W-1:0]           s_off;
  logic [bsmv_pkg::ORD_W-1:0]           up_sum;
  logic                                 term_ok;
  logic [bsmv_pkg::BANK_W-1:0]          bank_sel;
  logic [ADDR_W-1:0]                    coef_raddr;
  logic [ADDR_W-1:0]                    vec_raddr;

  // memories
  logic                                 clearing;
  logic [bsmv_pkg::VAL_W-1:0]           coef_rdata [bsmv_pkg::NUM_DIAGONALS];
  logic [bsmv_pkg::VAL_W-1:0]           vec_rdata;
  logic [ADDR_W-1:0]                    wr_addr_vec;
  logic [ADDR_W-1:0]                    wr_addr_coef;
  logic [bsmv_pkg::VAL_W-1:0]           wr_data;

  bsmv_pkg::mac_ctl_t                   mac_ctl;
  logic signed [bsmv_pkg::VAL_W-1:0]    mac_result;

  // effective order, diagonal count and offset list
  always_comb begin
    n_use = (bsmv_pkg::ORD_W'(dim_r) > ORD_MAX) ? ORD_MAX : bsmv_pkg::ORD_W'(dim_r);
    if (dcnt_r == '0) begin
      m_use = bsmv_pkg::DCNT_W'(1);
    end else if (dcnt_r > DIAG_MAX) begin
      m_use = DIAG_MAX;
    end else begin
      m_use = dcnt_r;
    end
    offs[0] = '0;
    for (int k = 1; k < bsmv_pkg::DIAG_LIMIT; k++) begin
      offs[k] = off_r[k-1];
    end
  end

  // item decode: fold to lower triangle, range check, first matching offset
  always_comb begin
    hi_idx   = (col_r > row_r) ? col_r : row_r;
    lo_idx   = (col_r > row_r) ? row_r : col_r;
    diff     = hi_idx - lo_idx;
    hit      = 1'b0;
    hit_bank = '0;
    for (int k = bsmv_pkg::DIAG_LIMIT - 1; k >= 0; k--) begin
      if ((bsmv_pkg::DCNT_W'(k) < m_use) && (offs[k] == diff)) begin
        hit      = 1'b1;
        hit_bank = bsmv_pkg::BANK_W'(k);
      end
    end
    range_bad   = 1'b0;
    exec_status = bsmv_pkg::ST_OK;
    query_go    = 1'b0;
    entry_we    = 1'b0;
    vec_we_op   = 1'b0;
    unique case (act_r)
      bsmv_pkg::ACT_ENTRY: begin
        range_bad = ({1'b0, hi_idx} >= n_use);
        if (range_bad) begin
          exec_status = bsmv_pkg::ST_RANGE;
        end else if (!hit) begin
          exec_status = bsmv_pkg::ST_NODIAG;
        end else begin
          entry_we = 1'b1;
        end
      end
      bsmv_pkg::ACT_VECTOR: begin
        range_bad = ({1'b0, row_r} >= n_use);
        if (range_bad) begin
          exec_status = bsmv_pkg::ST_RANGE;
        end else begin
          vec_we_op = 1'b1;
        end
      end
      bsmv_pkg::ACT_QUERY: begin
        range_bad = ({1'b0, row_r} >= n_use);
        if (range_bad) begin
          exec_status = bsmv_pkg::ST_RANGE;
        end else begin
          query_go = 1'b1;
        end
      end
      default: begin
        exec_status = bsmv_pkg::ST_OK;
      end
    endcase
  end

  // query step: even steps read the upper term (step 0 is the main term),
  // odd steps the lower term, of diagonal (step+1)/2
  always_comb begin
    k_raw   = (step_r + bsmv_pkg::STEP_W'(1)) >> 1;
    lower   = step_r[0];
    s_off   = '0;
    term_ok = 1'b0;
    if (k_raw < bsmv_pkg::STEP_W'(bsmv_pkg::DIAG_LIMIT)) begin
      s_off = offs[k_raw[bsmv_pkg::BANK_W-1:0]];
    end
    up_sum   = {1'b0, row_r} + {1'b0, s_off};
    bank_sel = k_raw[bsmv_pkg::BANK_W-1:0];
    if ((state_r == S_MAC) && (step_r < STEP_TERMS) &&
        (k_raw < bsmv_pkg::STEP_W'(m_use))) begin
      term_ok = lower ? (row_r >= s_off) : (up_sum < n_use);
    end
    coef_raddr = lower ? ADDR_W'(row_r - s_off) : ADDR_W'(row_r);
    vec_raddr  = lower ? ADDR_W'(row_r - s_off) : up_sum[ADDR_W-1:0];
  end

  // store write muxing: the reset sweep writes zero everywhere
  assign clearing     = (state_r == S_CLEAR);
  assign wr_addr_coef = clearing ? clr_addr_r : ADDR_W'(lo_idx);
  assign wr_addr_vec  = clearing ? clr_addr_r : ADDR_W'(row_r);
  assign wr_data      = clearing ? '0 : val_r;

  // one coefficient bank per diagonal
  for (genvar g = 0; g < bsmv_pkg::NUM_DIAGONALS; g++) begin : g_bank
    logic bank_we;
    assign bank_we = clearing ||
                     ((state_r == S_EXEC) && entry_we &&
                      (hit_bank == bsmv_pkg::BANK_W'(g)));
    bsmv_ram #(
      .DEPTH (bsmv_pkg::MAX_ORDER),
      .WIDTH (bsmv_pkg::VAL_W)
    ) u_coef (
      .clk   (clk),
      .we    (bank_we),
      .waddr (wr_addr_coef),
      .wdata (wr_data),
      .raddr (coef_raddr),
      .rdata (coef_rdata[g])
    );
  end

  bsmv_ram #(
    .DEPTH (bsmv_pkg::MAX_ORDER),
    .WIDTH (bsmv_pkg::VAL_W)
  ) u_vec (
    .clk   (clk),
    .we    (clearing || ((state_r == S_EXEC) && vec_we_op)),
    .waddr (wr_addr_vec),
    .wdata (wr_data),
    .raddr (vec_raddr),
    .rdata (vec_rdata)
  );

  // shared multiply-accumulate
  assign mac_ctl.clr     = (state_r == S_EXEC);
  assign mac_ctl.term_ok = term_ok_d_r;
  assign mac_ctl.acc_en  = (state_r == S_MAC);

  bsmv_mac u_mac (
    .clk    (clk),
    .ctl    (mac_ctl),
    .coef   (coef_rdata[bank_d_r]),
    .vec    (vec_rdata),
    .result (mac_result)
  );

  // sequencer, configuration and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_addr_r   <= '0;
      step_r       <= '0;
      term_ok_d_r  <= 1'b0;
      bank_d_r     <= '0;
      out_valid_r  <= 1'b0;
      out_status_r <= bsmv_pkg::ST_OK;
      dim_r        <= bsmv_pkg::DIM_W'(4096);
      dcnt_r       <= bsmv_pkg::DCNT_W'(5);
      off_r[0]     <= bsmv_pkg::OFF_W'(1);
      off_r[1]     <= bsmv_pkg::OFF_W'(63);
      off_r[2]     <= bsmv_pkg::OFF_W'(64);
      off_r[3]     <= bsmv_pkg::OFF_W'(65);
    end else begin
      out_valid_r <= 1'b0;
      term_ok_d_r <= term_ok;
      bank_d_r    <= bank_sel;

      if (cfg_we) begin
        unique case (cfg_index)
          bsmv_pkg::CFG_DIMENSION: dim_r    <= cfg_wdata;
          bsmv_pkg::CFG_DIAG_CNT:  dcnt_r   <= cfg_wdata[bsmv_pkg::DCNT_W-1:0];
          bsmv_pkg::CFG_OFFSET_1:  off_r[0] <= cfg_wdata[bsmv_pkg::OFF_W-1:0];
          bsmv_pkg::CFG_OFFSET_2:  off_r[1] <= cfg_wdata[bsmv_pkg::OFF_W-1:0];
          bsmv_pkg::CFG_OFFSET_3:  off_r[2] <= cfg_wdata[bsmv_pkg::OFF_W-1:0];
          bsmv_pkg::CFG_OFFSET_4:  off_r[3] <= cfg_wdata[bsmv_pkg::OFF_W-1:0];
          default: ;
        endcase
      end

      unique case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + ADDR_W'(1);
          if (clr_addr_r == CLR_LAST) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            act_r   <= in_action;
            row_r   <= in_row;
            col_r   <= in_column;
            val_r   <= in_value;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (query_go) begin
            step_r  <= '0;
            state_r <= S_MAC;
          end else begin
            out_valid_r   <= 1'b1;
            out_status_r  <= exec_status;
            out_product_r <= '0;
            state_r       <= S_IDLE;
          end
        end
        S_MAC: begin
          step_r <= step_r + bsmv_pkg::STEP_W'(1);
          if (step_r == STEP_LAST) begin
            state_r <= S_ROUND;
          end
        end
        S_ROUND: begin
          out_valid_r   <= 1'b1;
          out_status_r  <= bsmv_pkg::ST_OK;
          out_product_r <= mac_result;
          state_r       <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy        = (state_r != S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_product = out_product_r;

  // checks
  `BSMV_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
  `BSMV_ASSERT_NEXT(a_round_result, state_r == S_ROUND, out_valid, "query ended without result")
  `BSMV_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid, "result strobe longer than one cycle")
  `BSMV_ASSERT_SAME(a_clear_quiet, state_r == S_CLEAR, busy && !out_valid, "activity during sweep")
  `BSMV_ASSERT_SAME(a_err_zero, out_valid && (out_status != bsmv_pkg::ST_OK), out_product == '0, "error result with nonzero product")

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps

module tb;
  import bsmv_pkg::*;

  localparam logic [ACT_W-1:0] ACT_IGNORED = 2'd3;
  localparam logic [CIDX_W-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [CIDX_W-1:0] CFG_SPARE_7 = 3'd7;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 20;
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 44;

  typedef struct {
    logic [STAT_W-1:0]       status;
    logic signed [VAL_W-1:0] product;
  } matvec_result_t;

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic [ACT_W-1:0]         in_action;
  logic [ROW_W-1:0]         in_row;
  logic [ROW_W-1:0]         in_column;
  logic signed [VAL_W-1:0]  in_value;
  logic                     out_valid;
  logic [STAT_W-1:0]        out_status;
  logic signed [VAL_W-1:0]  out_product;
  logic                     cfg_we;
  logic [CIDX_W-1:0]        cfg_index;
  logic [CDAT_W-1:0]        cfg_wdata;

  // Shadow of the block: matrix bands, vector, registers
  logic [VAL_W-1:0]  band_mem [NUM_DIAGONALS][MAX_ORDER];
  logic [VAL_W-1:0]  vector_mem [MAX_ORDER];
  logic [DIM_W-1:0]  dim_shadow;
  logic [DCNT_W-1:0] diag_cnt_shadow;
  logic [OFF_W-1:0]  offset_shadow [OFFSET_REGS];

  matvec_result_t predicted_results[$];
  int error_count;
  int cycle_count;

  banded_symmetric_matvec_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_action  (in_action),
    .in_row     (in_row),
    .in_column  (in_column),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_status (out_status),
    .out_product(out_product),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor
  function automatic int order_now();
    return (dim_shadow > MAX_ORDER) ? MAX_ORDER : int'(dim_shadow);
  endfunction

  function automatic int diags_now();
    int cnt;
    cnt = int'(diag_cnt_shadow);
    if (cnt == 0) cnt = 1;
    if (cnt > DIAG_LIMIT) cnt = DIAG_LIMIT;
    return cnt;
  endfunction

  function automatic int band_offset(int k);
    if (k == 0 || k > OFFSET_REGS) return 0;
    return int'(offset_shadow[k-1]);
  endfunction

  function automatic logic signed [ACC_W-1:0] mac_term(logic [VAL_W-1:0] a,
                                                       logic [VAL_W-1:0] b);
    longint sa;
    longint sb;
    longint prod;
    sa = longint'($signed(a));
    sb = longint'($signed(b));
    prod = sa * sb;
    return ACC_W'(prod);
  endfunction

  // Applies one command to the shadow and returns its result beat
  function automatic matvec_result_t predict_matvec_beat(logic [ACT_W-1:0] act,
                                                         logic [ROW_W-1:0] r_in,
                                                         logic [ROW_W-1:0] c_in,
                                                         logic [VAL_W-1:0] val);
    matvec_result_t res;
    int n;
    int m;
    int r;
    int c;
    int tmp;
    int hit;
    int s;
    logic signed [ACC_W-1:0] acc_sum;
    logic signed [ACC_W-1:0] rounded;
    n = order_now();
    m = diags_now();
    r = int'(r_in);
    c = int'(c_in);
    res.status = ST_OK;
    res.product = '0;
    case (act)
      ACT_ENTRY: begin
        if (c > r) begin
          tmp = c;
          c = r;
          r = tmp;
        end
        if (r >= n) begin
          res.status = ST_RANGE;
        end else begin
          hit = -1;
          for (int k = 0; k < m; k++) begin
            if (hit < 0 && band_offset(k) == r - c) hit = k;
          end
          if (hit < 0) res.status = ST_NODIAG;
          else band_mem[hit][c] = val;
        end
      end
      ACT_VECTOR: begin
        if (r >= n) res.status = ST_RANGE;
        else vector_mem[r] = val;
      end
      ACT_QUERY: begin
        if (r >= n) begin
          res.status = ST_RANGE;
        end else begin
          acc_sum = mac_term(band_mem[0][r], vector_mem[r]);
          for (int k = 1; k < m; k++) begin
            s = band_offset(k);
            if (r >= s) acc_sum += mac_term(band_mem[k][r-s], vector_mem[r-s]);
            if (r + s < n) acc_sum += mac_term(band_mem[k][r], vector_mem[r+s]);
          end
          // round half up to Q12.20, then clamp
          rounded = (acc_sum + ACC_W'(524288)) >>> FRAC_W;
          if (rounded > $signed(ACC_W'(32'h7FFF_FFFF)))
            res.product = 32'h7FFF_FFFF;
          else if (rounded < -$signed(ACC_W'(33'h0_8000_0000)))
            res.product = 32'h8000_0000;
          else
            res.product = rounded[VAL_W-1:0];
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------- checker
  always @(posedge clk) begin
    matvec_result_t exp_beat;
    if (rst_n && out_valid) begin
      if (predicted_results.size() == 0) begin
        $error("result beat with nothing expected: status %0d product %h",
               out_status, out_product);
        error_count++;
      end else begin
        exp_beat = predicted_results.pop_front();
        if (out_status !== exp_beat.status) begin
          $error("status: expected %0d, got %0d", exp_beat.status, out_status);
          error_count++;
        end
        if (out_product !== exp_beat.product) begin
          $error("product: expected %h, got %h", exp_beat.product, out_product);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- drivers
  task automatic issue_command(input logic [ACT_W-1:0] act, input int r, input int c,
                               input logic [VAL_W-1:0] val);
    start     <= 1'b1;
    in_action <= act;
    in_row    <= ROW_W'(r);
    in_column <= ROW_W'(c);
    in_value  <= val;
    do @(posedge clk); while (busy);
    predicted_results.push_back(predict_matvec_beat(act, ROW_W'(r), ROW_W'(c), val));
  endtask

  task automatic hold_off(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Every beat answers, so an empty queue means the block is idle
  task automatic drain_results();
    start <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One write beat, then one idle cycle with the write enable low
  task automatic write_register(input logic [CIDX_W-1:0] idx, input int data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CDAT_W'(data);
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_DIMENSION: dim_shadow = DIM_W'(data);
      CFG_DIAG_CNT:  diag_cnt_shadow = DCNT_W'(data);
      CFG_OFFSET_1:  offset_shadow[0] = OFF_W'(data);
      CFG_OFFSET_2:  offset_shadow[1] = OFF_W'(data);
      CFG_OFFSET_3:  offset_shadow[2] = OFF_W'(data);
      CFG_OFFSET_4:  offset_shadow[3] = OFF_W'(data);
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return 0;
    if (sel < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return VAL_W'($urandom_range(0, 32'h7F_FFFF)) - 32'h40_0000;
    if (sel < 85) return $urandom;
    case ($urandom_range(0, 4))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'h0000_0001;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  // ---------------------------------------------------------------- tests
  // Default registers: clear check, saturation, folding, missing bands, ties
  task automatic test_default_band();
    issue_command(ACT_QUERY, 5, 0, 32'h0);
    issue_command(ACT_VECTOR, 0, 0, 32'h7FFF_FFFF);
    issue_command(ACT_VECTOR, 4095, 0, 32'h8000_0000);
    issue_command(ACT_ENTRY, 0, 0, 32'h7FFF_FFFF);
    issue_command(ACT_QUERY, 0, 0, 32'h0);
    issue_command(ACT_ENTRY, 4095, 4095, 32'h7FFF_FFFF);
    issue_command(ACT_QUERY, 4095, 0, 32'h0);
    issue_command(ACT_ENTRY, 1, 64, 32'h0010_0000);
    issue_command(ACT_ENTRY, 65, 0, 32'hFFF0_0000);
    issue_command(ACT_ENTRY, 0, 1, 32'h0020_0000);
    issue_command(ACT_ENTRY, 64, 0, 32'h0008_0000);
    issue_command(ACT_ENTRY, 2, 0, 32'h1234_5678);
    issue_command(ACT_ENTRY, 0, 4095, 32'h1234_5678);
    issue_command(ACT_VECTOR, 0, 0, 32'h0010_0000);
    issue_command(ACT_VECTOR, 1, 0, 32'h0030_0000);
    issue_command(ACT_VECTOR, 64, 0, 32'h0010_0000);
    issue_command(ACT_VECTOR, 65, 0, 32'hFFE0_0000);
    issue_command(ACT_QUERY, 0, 0, 32'h0);
    issue_command(ACT_QUERY, 64, 0, 32'h0);
    issue_command(ACT_QUERY, 65, 0, 32'h0);
    issue_command(ACT_IGNORED, 4095, 4095, 32'hFFFF_FFFF);
    // half-LSB ties round toward plus infinity
    issue_command(ACT_ENTRY, 10, 10, 32'h0000_0001);
    issue_command(ACT_VECTOR, 10, 0, 32'h0008_0000);
    issue_command(ACT_QUERY, 10, 0, 32'h0);
    issue_command(ACT_ENTRY, 10, 10, 32'hFFFF_FFFF);
    issue_command(ACT_QUERY, 10, 0, 32'h0);
    drain_results();
  endtask

  // Register extremes: empty matrix, clamped order and count, odd offsets
  task automatic test_register_extremes();
    write_register(CFG_DIMENSION, 0);
    issue_command(ACT_ENTRY, 0, 0, 32'h1);
    issue_command(ACT_VECTOR, 0, 0, 32'h1);
    issue_command(ACT_QUERY, 0, 0, 32'h0);
    issue_command(ACT_IGNORED, 0, 0, 32'h0);
    drain_results();

    write_register(CFG_DIMENSION, 8191);
    write_register(CFG_DIAG_CNT, 7);
    issue_command(ACT_QUERY, 4095, 0, 32'h0);
    issue_command(ACT_ENTRY, 4030, 4095, 32'h0040_0000);
    issue_command(ACT_QUERY, 4030, 0, 32'h0);
    drain_results();

    write_register(CFG_DIMENSION, 1);
    write_register(CFG_DIAG_CNT, 0);
    issue_command(ACT_QUERY, 0, 0, 32'h0);
    issue_command(ACT_ENTRY, 0, 1, 32'h1);
    issue_command(ACT_VECTOR, 1, 0, 32'h1);
    drain_results();

    // widest offset reaches across the whole matrix
    write_register(CFG_DIMENSION, 4096);
    write_register(CFG_DIAG_CNT, 2);
    write_register(CFG_OFFSET_1, 4095);
    issue_command(ACT_ENTRY, 4095, 0, 32'h0018_0000);
    issue_command(ACT_VECTOR, 4095, 0, 32'h0020_0000);
    issue_command(ACT_QUERY, 0, 0, 32'h0);
    issue_command(ACT_QUERY, 4095, 0, 32'h0);
    drain_results();

    // zero and duplicate offsets are summed literally
    write_register(CFG_DIAG_CNT, 3);
    write_register(CFG_OFFSET_1, 0);
    write_register(CFG_OFFSET_2, 0);
    issue_command(ACT_ENTRY, 7, 7, 32'h0010_0000);
    issue_command(ACT_VECTOR, 7, 0, 32'h0030_0000);
    issue_command(ACT_QUERY, 7, 0, 32'h0);
    drain_results();

    // unordered offsets; first match wins
    write_register(CFG_DIMENSION, 16);
    write_register(CFG_DIAG_CNT, 5);
    write_register(CFG_OFFSET_1, 9);
    write_register(CFG_OFFSET_2, 3);
    write_register(CFG_OFFSET_3, 3);
    write_register(CFG_OFFSET_4, 4095);
    write_register(CFG_SPARE_6, 8191);
    write_register(CFG_SPARE_7, 0);
    issue_command(ACT_ENTRY, 3, 6, 32'hFFC0_0000);
    issue_command(ACT_ENTRY, 12, 3, 32'h0008_0000);
    issue_command(ACT_VECTOR, 3, 0, 32'h0010_0000);
    issue_command(ACT_VECTOR, 12, 0, 32'hFFF0_0000);
    issue_command(ACT_QUERY, 3, 0, 32'h0);
    issue_command(ACT_QUERY, 6, 0, 32'h0);
    issue_command(ACT_ENTRY, 15, 0, 32'h1);
    drain_results();
  endtask

  task automatic randomize_registers();
    int sel;
    int dim;
    int base;
    sel = $urandom_range(0, 99);
    if (sel < 70) dim = $urandom_range(2, 48);
    else if (sel < 80) dim = 4096;
    else if (sel < 90) dim = $urandom_range(4097, 8191);
    else if (sel < 95) dim = 0;
    else dim = 1;
    write_register(CFG_DIMENSION, dim);
    write_register(CFG_DIAG_CNT, $urandom_range(0, 7));
    if ($urandom_range(0, 99) < 80) begin
      base = 0;
      for (int k = 0; k < OFFSET_REGS; k++) begin
        base += $urandom_range(1, 4);
        write_register(CFG_OFFSET_1 + CIDX_W'(k), base);
      end
    end else begin
      for (int k = 0; k < OFFSET_REGS; k++)
        write_register(CFG_OFFSET_1 + CIDX_W'(k),
                       ($urandom_range(0, 1) != 0) ? $urandom_range(0, 4) : $urandom_range(0, 4095));
    end
  endtask

  // Random phases: mostly in-band writes and in-range rows, some noise
  task automatic test_random_traffic();
    int n;
    int m;
    int sel;
    int r;
    int c;
    int k;
    int off;
    int tmp;
    bit no_gaps;
    logic [ACT_W-1:0] act;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      randomize_registers();
      n = order_now();
      m = diags_now();
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        sel = $urandom_range(0, 99);
        if (sel < 35) act = ACT_ENTRY;
        else if (sel < 65) act = ACT_VECTOR;
        else if (sel < 95) act = ACT_QUERY;
        else act = ACT_IGNORED;
        if (n > 0 && $urandom_range(0, 9) != 0) r = $urandom_range(0, n - 1);
        else r = $urandom_range(0, 4095);
        c = $urandom_range(0, 4095);
        if (act == ACT_ENTRY && n > 0 && $urandom_range(0, 3) != 0) begin
          k = $urandom_range(0, m - 1);
          off = band_offset(k);
          if (off < n) begin
            c = $urandom_range(0, n - 1 - off);
            r = c + off;
            if ($urandom_range(0, 1) != 0) begin
              tmp = c;
              c = r;
              r = tmp;
            end
          end
        end
        issue_command(act, r, c, pick_value());
        if (!no_gaps) hold_off(pick_gap());
      end
      drain_results();
    end
  endtask

  // ---------------------------------------------------------------- sequence
  initial begin
    error_count = 0;
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_action <= '0;
    in_row    <= '0;
    in_column <= '0;
    in_value  <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    for (int k = 0; k < NUM_DIAGONALS; k++)
      for (int a = 0; a < MAX_ORDER; a++) band_mem[k][a] = '0;
    for (int a = 0; a < MAX_ORDER; a++) vector_mem[a] = '0;
    dim_shadow = 13'd4096;
    diag_cnt_shadow = 3'd5;
    offset_shadow[0] = 12'd1;
    offset_shadow[1] = 12'd63;
    offset_shadow[2] = 12'd64;
    offset_shadow[3] = 12'd65;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    // stores are swept after reset; wait for the sweep to finish
    @(posedge clk);
    do @(posedge clk); while (busy);

    test_default_band();
    test_register_extremes();
    test_random_traffic();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && predicted_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/bsmv_pkg.sv
rtl/bsmv_ram.sv
rtl/bsmv_mac.sv
rtl/banded_symmetric_matvec_unit.sv
test/tb.sv
